// ----- rtl/qep_pkg.sv -----
// Shared constants and the transition table for the quadrature position tracker.
package qep_pkg;

  localparam int unsigned PosW  = 32;
  localparam int unsigned TimeW = 32;
  localparam int unsigned DebW  = 16;
  localparam int unsigned StepW = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_POS  = 2'd0,
    REG_MAX_POS  = 2'd1,
    REG_WRAP_EN  = 2'd2,
    REG_DEBOUNCE = 2'd3
  } cfg_reg_t;

  localparam logic [PosW-1:0] MinPosReset = 32'h8000_0000;
  localparam logic [PosW-1:0] MaxPosReset = 32'h7FFF_FFFF;

  localparam logic [1:0] PinsDetent = 2'b11;

  localparam logic signed [StepW-1:0] StepMax = 3'sd2;
  localparam logic signed [StepW-1:0] StepMin = -3'sd2;

  // Gray-code transition table, indexed by {previous pins, current pins}.
  function automatic logic signed [1:0] step_delta(input logic [3:0] idx);
    logic signed [1:0] d;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: d = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
      default: d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/quadrature_encoder_position.sv -----
// Quadrature encoder position tracker: debounce, x1 detent decode, bounded position.
// Pipeline: input reg, decode, tick difference, position update / output reg.
// Throughput: one input beat per cycle while in_stall is low; only beats that move the detent count give a result.
// The position update is a loop through the pos_r register (34-bit add plus bound compares).
// Reset (synchronous, rst_n low): pipeline emptied, tracking state zeroed, bounds full range.
module quadrature_encoder_position (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_pin_a,
  input  logic                                 in_pin_b,
  input  logic [qep_pkg::TimeW-1:0]            in_time_ms,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [qep_pkg::StepW-1:0]     out_steps,
  output logic signed [qep_pkg::PosW-1:0]      out_position,
  input  logic                                 cfg_we,
  input  logic [qep_pkg::CfgIdxW-1:0]          cfg_index,
  input  logic [qep_pkg::CfgDataW-1:0]         cfg_wdata
);

  localparam int unsigned SumW = qep_pkg::PosW + 2;

  // configuration
  logic [qep_pkg::PosW-1:0]  min_pos_r, max_pos_r;
  logic                      wrap_en_r;
  logic [qep_pkg::DebW-1:0]  debounce_r;

  // tracking state
  logic                      primed_r;
  logic [1:0]                last_pins_r;
  logic [qep_pkg::PosW-1:0]  acc_r, detent_r, pos_r;
  logic [qep_pkg::TimeW-1:0] last_time_r;

  // pipeline
  logic                      q_v_r, a_v_r, b_v_r, o_v_r;
  logic [1:0]                q_pins_r;
  logic [qep_pkg::TimeW-1:0] q_time_r;
  logic [qep_pkg::PosW-1:0]  a_dn_r, a_do_r;
  logic [qep_pkg::PosW-1:0]  b_ticks_r;
  logic signed [qep_pkg::StepW-1:0] out_steps_r;
  logic [qep_pkg::PosW-1:0]  out_pos_r;

  logic o_free, b_nz, b_go, b_free, a_go, a_free, q_go, q_free;

  assign o_free = !o_v_r || !out_stall;
  assign b_nz   = |b_ticks_r;
  assign b_go   = b_v_r && (o_free || !b_nz);
  assign b_free = !b_v_r || b_go;
  assign a_go   = a_v_r && b_free;
  assign a_free = !a_v_r || a_go;
  assign q_go   = q_v_r && a_free;
  assign q_free = !q_v_r || q_go;

  assign in_stall     = !q_free;
  assign out_valid    = o_v_r;
  assign out_steps    = out_steps_r;
  assign out_position = out_pos_r;

  // ---------------- decode stage ----------------
  logic [qep_pkg::TimeW-1:0] elapsed;
  logic                      pass;
  logic signed [1:0]         delta;
  logic [qep_pkg::PosW-1:0]  acc_nxt, detent_nxt, last_time_nxt;
  logic [1:0]                last_pins_nxt;

  always_comb begin
    elapsed       = q_time_r - last_time_r;
    pass          = elapsed >= {{(qep_pkg::TimeW-qep_pkg::DebW){1'b0}}, debounce_r};
    delta         = qep_pkg::step_delta({last_pins_r, q_pins_r});
    acc_nxt       = acc_r;
    detent_nxt    = detent_r;
    last_pins_nxt = last_pins_r;
    last_time_nxt = last_time_r;
    if (!primed_r) begin
      last_pins_nxt = q_pins_r;
      last_time_nxt = q_time_r;
    end else if (pass) begin
      last_time_nxt = q_time_r;
      if (q_pins_r != last_pins_r) begin
        acc_nxt       = acc_r + {{(qep_pkg::PosW-2){delta[1]}}, delta};
        last_pins_nxt = q_pins_r;
        if (q_pins_r == qep_pkg::PinsDetent) begin
          detent_nxt = {{2{acc_nxt[qep_pkg::PosW-1]}}, acc_nxt[qep_pkg::PosW-1:2]};
        end
      end
    end
  end

  // ---------------- position stage ----------------
  logic signed [SumW-1:0]    sum, hi_x, lo_x;
  logic                      gt_hi, lt_lo, crossed, clip_lo;
  logic [qep_pkg::PosW-1:0]  hi_v, lo_v, p_bound, pos_nxt;
  logic signed [qep_pkg::PosW-1:0] ticks_s;
  logic signed [qep_pkg::StepW-1:0] steps_sat;

  always_comb begin
    ticks_s = signed'(b_ticks_r);
    hi_v    = max_pos_r;
    lo_v    = min_pos_r;
    sum     = signed'({{2{pos_r[qep_pkg::PosW-1]}}, pos_r})
            + signed'({{2{b_ticks_r[qep_pkg::PosW-1]}}, b_ticks_r});
    hi_x    = signed'({{2{hi_v[qep_pkg::PosW-1]}}, hi_v});
    lo_x    = signed'({{2{lo_v[qep_pkg::PosW-1]}}, lo_v});
    gt_hi   = sum > hi_x;
    lt_lo   = sum < lo_x;
    crossed = signed'(hi_v) < signed'(lo_v);
    // after clamping to max, the min check sees max when the sum was too high
    clip_lo = gt_hi ? crossed : lt_lo;
    p_bound = clip_lo ? lo_v : hi_v;
    if (!gt_hi && !lt_lo) begin
      pos_nxt = sum[qep_pkg::PosW-1:0];
    end else if (wrap_en_r) begin
      pos_nxt = (p_bound == hi_v) ? lo_v : hi_v;
    end else begin
      pos_nxt = p_bound;
    end
    if (ticks_s > 32'sd2) begin
      steps_sat = qep_pkg::StepMax;
    end else if (ticks_s < -32'sd2) begin
      steps_sat = qep_pkg::StepMin;
    end else begin
      steps_sat = ticks_s[qep_pkg::StepW-1:0];
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pos_r   <= qep_pkg::MinPosReset;
      max_pos_r   <= qep_pkg::MaxPosReset;
      wrap_en_r   <= 1'b0;
      debounce_r  <= '0;
      primed_r    <= 1'b0;
      last_pins_r <= '0;
      acc_r       <= '0;
      detent_r    <= '0;
      pos_r       <= '0;
      last_time_r <= '0;
      q_v_r       <= 1'b0;
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      o_v_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          qep_pkg::REG_MIN_POS:  min_pos_r  <= cfg_wdata[qep_pkg::PosW-1:0];
          qep_pkg::REG_MAX_POS:  max_pos_r  <= cfg_wdata[qep_pkg::PosW-1:0];
          qep_pkg::REG_WRAP_EN:  wrap_en_r  <= cfg_wdata[0];
          qep_pkg::REG_DEBOUNCE: debounce_r <= cfg_wdata[qep_pkg::DebW-1:0];
          default: ;
        endcase
      end

      if (q_free) begin
        q_v_r <= in_valid;
      end
      if (q_go) begin
        primed_r    <= 1'b1;
        last_pins_r <= last_pins_nxt;
        acc_r       <= acc_nxt;
        detent_r    <= detent_nxt;
        last_time_r <= last_time_nxt;
      end
      if (a_free) begin
        a_v_r <= q_go;
      end
      if (b_free) begin
        b_v_r <= a_go;
      end
      if (b_go) begin
        pos_r <= pos_nxt;
      end
      if (o_free) begin
        o_v_r <= b_go && b_nz;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (q_free) begin
      q_pins_r <= {in_pin_a, in_pin_b};
      q_time_r <= in_time_ms;
    end
    if (a_free) begin
      a_dn_r <= detent_nxt;
      a_do_r <= detent_r;
    end
    if (b_free) begin
      b_ticks_r <= a_dn_r - a_do_r;
    end
    if (b_go && b_nz) begin
      out_steps_r <= steps_sat;
      out_pos_r   <= pos_nxt;
    end
  end

endmodule

// ----- bench/quadrature_encoder_position_tb.sv -----
// Self-checking testbench for the quadrature encoder position tracker.
`timescale 1ns / 100ps

module quadrature_encoder_position_tb;

  localparam int PipeLatency   = 8;
  localparam int WatchdogLimit = 4000;
  localparam int RandomPhases  = 9;
  localparam int PhaseSamples  = 88;
  localparam longint PosFloor  = -(longint'(1) <<< 31);
  localparam longint PosCeil   = (longint'(1) <<< 31) - 1;

  // movement per {previous pins, current pins}
  localparam int GrayStep [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};

  typedef struct {
    logic        a;
    logic        b;
    logic [31:0] t;
  } pin_sample_t;

  typedef struct {
    logic signed [qep_pkg::StepW-1:0] steps;
    logic signed [qep_pkg::PosW-1:0]  position;
  } detent_report_t;

  logic                             clk;
  logic                             rst_n        = 1'b0;
  logic                             in_valid     = 1'b0;
  logic                             in_stall;
  logic                             in_pin_a     = 1'b0;
  logic                             in_pin_b     = 1'b0;
  logic [qep_pkg::TimeW-1:0]        in_time_ms   = '0;
  logic                             out_valid;
  logic                             out_stall    = 1'b0;
  logic signed [qep_pkg::StepW-1:0] out_steps;
  logic signed [qep_pkg::PosW-1:0]  out_position;
  logic                             cfg_we       = 1'b0;
  logic [qep_pkg::CfgIdxW-1:0]      cfg_index    = qep_pkg::REG_MIN_POS;
  logic [qep_pkg::CfgDataW-1:0]     cfg_wdata    = '0;

  quadrature_encoder_position u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pin_a     (in_pin_a),
    .in_pin_b     (in_pin_b),
    .in_time_ms   (in_time_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_steps    (out_steps),
    .out_position (out_position),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // tracker mirror: configuration
  logic signed [31:0] lo_bound   = qep_pkg::MinPosReset;
  logic signed [31:0] hi_bound   = qep_pkg::MaxPosReset;
  logic               wrap_on    = 1'b0;
  logic [15:0]        settle_ms  = '0;
  // tracker mirror: state
  logic               primed_q   = 1'b0;
  logic [1:0]         prev_pins  = '0;
  logic [31:0]        move_acc   = '0;
  logic [31:0]        detent_cnt = '0;
  logic [31:0]        shown_cnt  = '0;
  logic [31:0]        pos_q      = '0;
  logic [31:0]        accept_ms  = '0;

  pin_sample_t    sample_queue [$];
  detent_report_t detent_reports [$];

  bit          steady = 1'b0;
  int          error_count = 0;
  int          samples_taken = 0;
  int          samples_dropped = 0;
  int          reports_checked = 0;
  int          settings_used = 0;
  int          idle_cycles = 0;
  int          gen_count = 0;
  logic [31:0] gen_stamp = '0;
  logic [1:0]  gen_pins = '0;

  // Advance the tracker by one accepted beat; queue the report it produces.
  function automatic void track_sample(input logic a, input logic b, input logic [31:0] t);
    logic [1:0]     pins;
    longint         ticks;
    longint         lo;
    longint         hi;
    longint         p;
    detent_report_t rep;
    pins = {a, b};
    samples_taken++;
    if (!primed_q) begin
      primed_q  = 1'b1;
      prev_pins = pins;
      accept_ms = t;
    end else if ((t - accept_ms) >= {16'd0, settle_ms}) begin
      accept_ms = t;
      if (pins != prev_pins) begin
        move_acc = move_acc + 32'(GrayStep[{prev_pins, pins}]);
        if (pins == qep_pkg::PinsDetent) detent_cnt = $signed(move_acc) >>> 2;
        prev_pins = pins;
      end
    end else begin
      samples_dropped++;
    end
    // bounds are enforced on every beat, report or not
    ticks = longint'($signed(detent_cnt - shown_cnt));
    shown_cnt = detent_cnt;
    lo = longint'(lo_bound);
    hi = longint'(hi_bound);
    p  = longint'($signed(pos_q)) + ticks;
    if (!(p <= hi && p >= lo)) begin
      if (p > hi) p = hi;
      if (p < lo) p = lo;
      if (wrap_on) p = (p == hi) ? lo : hi;
    end
    pos_q = p[31:0];
    if (ticks != 0) begin
      if (ticks > 2) ticks = 2;
      if (ticks < -2) ticks = -2;
      rep.steps    = ticks[qep_pkg::StepW-1:0];
      rep.position = pos_q;
      detent_reports.push_back(rep);
    end
  endfunction

  // input side
  always @(posedge clk) begin : drive_samples
    pin_sample_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) track_sample(in_pin_a, in_pin_b, in_time_ms);
      if (!in_valid || !in_stall) begin
        if (sample_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 17)) begin
          nxt = sample_queue.pop_front();
          in_valid   <= 1'b1;
          in_pin_a   <= nxt.a;
          in_pin_b   <= nxt.b;
          in_time_ms <= nxt.t;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin : check_reports
    detent_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (detent_reports.size() == 0) begin
        error_count++;
        $display("%0t: unexpected report, expected none, got steps %0d position %0d",
                 $time, out_steps, out_position);
      end else begin
        want = detent_reports.pop_front();
        reports_checked++;
        if (out_steps !== want.steps) begin
          error_count++;
          $display("%0t: steps mismatch, expected %0d, got %0d", $time, want.steps, out_steps);
        end
        if (out_position !== want.position) begin
          error_count++;
          $display("%0t: position mismatch, expected %0d, got %0d",
                   $time, want.position, out_position);
        end
      end
    end
    out_stall <= !steady && ($urandom_range(0, 99) < 17);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WatchdogLimit);
    $display("%0t: no beat for %0d cycles, %0d reports outstanding",
             $time, WatchdogLimit, detent_reports.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [31:0] pick_dt();
    if (settle_ms == 0) begin
      return ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(0, 3));
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2: return 32'($urandom_range(0, settle_ms - 1));
        3:       return $urandom();
        default: return {16'd0, settle_ms} + 32'($urandom_range(0, 2));
      endcase
    end
  endfunction

  // one gray-code step; cw counts up
  function automatic logic [1:0] rotate(input logic [1:0] p, input bit cw);
    logic [1:0] n;
    case (p)
      2'b11:   n = cw ? 2'b01 : 2'b10;
      2'b01:   n = cw ? 2'b00 : 2'b11;
      2'b00:   n = cw ? 2'b10 : 2'b01;
      default: n = cw ? 2'b11 : 2'b00;
    endcase
    return n;
  endfunction

  task automatic queue_sample(input logic [1:0] p, input logic [31:0] dt);
    gen_stamp = gen_stamp + dt;
    sample_queue.push_back('{p[1], p[0], gen_stamp});
    gen_pins = p;
    gen_count++;
  endtask

  task automatic queue_turn(input bit cw, input int detents);
    repeat (4 * detents) queue_sample(rotate(gen_pins, cw), pick_dt());
  endtask

  // Keeps turning but hops over 11 with a double-pin change, so the
  // accumulator runs ahead; closing on 11 then moves several detents at once.
  task automatic queue_spin(input bit cw, input int moves);
    logic [1:0] n;
    repeat (moves) begin
      n = rotate(gen_pins, cw);
      if (n == qep_pkg::PinsDetent) n = rotate(n, cw);
      queue_sample(n, pick_dt());
    end
    while (gen_pins != qep_pkg::PinsDetent) queue_sample(rotate(gen_pins, cw), pick_dt());
  endtask

  task automatic queue_random_run(input int target);
    int         start;
    bit         cw;
    logic [1:0] r;
    start = gen_count;
    while (gen_count - start < target) begin
      cw = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8: queue_turn(cw, $urandom_range(1, 3));
        9, 10, 11: queue_spin(cw, $urandom_range(6, 20));
        12, 13, 14, 15: begin
          r = rotate(gen_pins, cw);
          queue_sample(r, pick_dt());
          queue_sample(rotate(r, !cw), pick_dt());
        end
        default: repeat ($urandom_range(1, 4)) queue_sample(2'($urandom()), pick_dt());
      endcase
    end
  endtask

  task automatic write_reg(input qep_pkg::cfg_reg_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      qep_pkg::REG_MIN_POS:  lo_bound  = val;
      qep_pkg::REG_MAX_POS:  hi_bound  = val;
      qep_pkg::REG_WRAP_EN:  wrap_on   = val[0];
      qep_pkg::REG_DEBOUNCE: settle_ms = val[15:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [31:0] lo, input logic [31:0] hi,
                               input logic wrap, input logic [15:0] deb);
    write_reg(qep_pkg::REG_MIN_POS, lo);
    write_reg(qep_pkg::REG_MAX_POS, hi);
    write_reg(qep_pkg::REG_WRAP_EN, {31'd0, wrap});
    write_reg(qep_pkg::REG_DEBOUNCE, {16'd0, deb});
    settings_used++;
  endtask

  // let every queued beat go through and the pipeline run dry
  task automatic wait_quiet();
    while (sample_queue.size() != 0 || in_valid || detent_reports.size() != 0)
      @(posedge clk);
    repeat (PipeLatency) @(posedge clk);
  endtask

  initial begin
    longint     c;
    longint     lo_l;
    longint     hi_l;
    logic       wrap;
    logic [15:0] deb;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: priming, time wrap, both directions, double-pin change
    gen_stamp = 32'hFFFF_FFFC;
    queue_sample(2'b11, 0);
    queue_sample(2'b01, 2);
    queue_sample(2'b00, 2);
    queue_sample(2'b10, 2);
    queue_sample(2'b11, 2);
    queue_turn(1'b0, 1);
    queue_sample(2'b00, 1);
    queue_sample(2'b11, 1);
    queue_sample(2'b11, 1);
    wait_quiet();

    // longest debounce: just short, exactly on the interval twice, then short again
    apply_setting(qep_pkg::MinPosReset, qep_pkg::MaxPosReset, 1'b0, 16'hFFFF);
    queue_sample(2'b01, 32'd65534);
    queue_sample(2'b01, 32'd1);
    queue_sample(2'b00, 32'd65535);
    queue_sample(2'b10, 32'd0);
    wait_quiet();

    // narrow window: clamp, then wrap
    apply_setting(-32'sd1, 32'd0, 1'b0, 16'd0);
    queue_turn(1'b1, 1);
    wait_quiet();
    apply_setting(-32'sd1, 32'd0, 1'b1, 16'd0);
    queue_turn(1'b1, 1);
    wait_quiet();

    for (int k = 0; k < RandomPhases; k++) begin
      steady = (k == 4);
      case (k)
        0: apply_setting(qep_pkg::MaxPosReset, qep_pkg::MaxPosReset, 1'b0, 16'd0);
        1: apply_setting(qep_pkg::MinPosReset, qep_pkg::MaxPosReset, 1'b1,
                         16'($urandom_range(1, 5)));
        2: apply_setting(qep_pkg::MinPosReset, qep_pkg::MaxPosReset, 1'($urandom()),
                         16'hFFFF);
        default: begin
          c    = longint'($signed(pos_q));
          lo_l = c - $urandom_range(0, 6);
          hi_l = c + $urandom_range(0, 6);
          if (lo_l < PosFloor) lo_l = PosFloor;
          if (hi_l > PosCeil) hi_l = PosCeil;
          wrap = 1'($urandom_range(0, 1));
          deb  = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 8));
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: apply_setting(lo_l[31:0], hi_l[31:0], wrap, deb);
            8, 9, 10:               apply_setting(hi_l[31:0], lo_l[31:0], wrap, deb);
            11, 12, 13, 14:         apply_setting($urandom(), $urandom(), wrap, deb);
            default: apply_setting(qep_pkg::MinPosReset, qep_pkg::MaxPosReset, wrap, deb);
          endcase
        end
      endcase
      queue_random_run(PhaseSamples);
      wait_quiet();
    end
    steady = 1'b0;

    $display("Covered %0d samples (%0d dropped by debounce), %0d detent reports checked",
             samples_taken, samples_dropped, reports_checked);
    $display("over %0d bound/wrap/debounce settings, incl. pinned, full-range and crossed bounds",
             settings_used);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
